FILE: src/jsu_pkg.sv
package jsu_pkg;

  localparam int QDEPTH = 2;

  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6e;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;

  // leading byte of any 0xd800..0xdfff code in utf-8
  localparam logic [7:0] SURR_LEAD    = 8'hed;

  localparam logic [5:0] HIGH_SURR_TOP = 6'b110110;
  localparam logic [5:0] LOW_SURR_TOP  = 6'b110111;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } utf8_t;

  // one decoded input word: held surrogate, up to six bytes, second surrogate
  typedef struct packed {
    logic            h0_v;
    logic [9:0]      h0;
    logic [5:0][7:0] body;
    logic [2:0]      body_n;
    logic            h1_v;
    logic [9:0]      h1;
    logic            last;
  } entry_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [7:0] map_esc(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_B:    r = 8'h08;
      CH_F:    r = 8'h0c;
      CH_N:    r = 8'h0a;
      CH_R:    r = 8'h0d;
      CH_T:    r = 8'h09;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t u;
    u = '0;
    if (cp <= 21'h7f) begin
      u.b[0] = cp[7:0];
      u.n    = 3'd1;
    end else if (cp <= 21'h7ff) begin
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
      u.n    = 3'd2;
    end else if (cp <= 21'hffff) begin
      u.b[0] = {4'he, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
      u.n    = 3'd3;
    end else begin
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
      u.n    = 3'd4;
    end
    return u;
  endfunction

  // byte i of the three-byte encoding of 0xd800 + h
  function automatic logic [7:0] surr_byte(input logic [9:0] h, input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd1:    r = {4'ha, h[9:6]};
      2'd2:    r = {2'b10, h[5:0]};
      default: r = SURR_LEAD;
    endcase
    return r;
  endfunction

endpackage

FILE: src/json_string_unescape_utf8.sv
// JSON string unescaper: one raw byte of a string body per input word, unescaped
// UTF-8 bytes out, one byte per output word. A front stage decodes each byte
// (escapes, four-digit unicode escapes, surrogate pairing) into a short record
// of up to nine bytes and writes it into a two-entry queue; a back stage
// walks the record and sends one byte per cycle through a registered output
// while the output is not stalled. An input word is taken every cycle while
// the queue has room, so plain text keeps that rate, each byte passing through
// the queue and the output register; a word that expands to n bytes holds the
// back stage for all n of them and the queue absorbs it, stalling the input
// only once the queue holds two words. A string's final word that produces
// nothing still gives one empty word flagged as end of string.
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last_of_run,
  output logic       out_end_of_string
);
  import jsu_pkg::*;

  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wdata, q_rdata;

  assign in_stall = q_full;

  jsu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  jsu_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  jsu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_rdata           (q_rdata),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_string (out_end_of_string)
  );

endmodule

FILE: src/jsu_front.sv
module jsu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            in_last_byte,
  input  logic            q_full,
  output logic            q_push,
  output jsu_pkg::entry_t q_wdata
);
  import jsu_pkg::*;

  logic            esc_r, esc_nxt;
  logic            hex_r, hex_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [2:0][7:0] chars_r, chars_nxt;
  logic [9:0]      held_r, held_nxt;
  logic            held_v_r, held_v_nxt;

  logic            acc;
  logic [4:0]      nib_in;
  logic [4:0]      nib0, nib1, nib2;
  logic [15:0]     cp16;
  utf8_t           u;
  entry_t          e;

  assign acc = in_valid && !q_full;

  always_comb begin
    nib_in     = hex_nib(in_byte);
    nib0       = hex_nib(chars_r[0]);
    nib1       = hex_nib(chars_r[1]);
    nib2       = hex_nib(chars_r[2]);
    cp16       = {nib0[3:0], nib1[3:0], nib2[3:0], nib_in[3:0]};
    u          = '0;
    e          = '0;
    esc_nxt    = esc_r;
    hex_nxt    = hex_r;
    cnt_nxt    = cnt_r;
    chars_nxt  = chars_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;

    if (hex_r) begin
      if (nib_in[4]) begin
        if (cnt_r != 2'd3) begin
          chars_nxt[cnt_r] = in_byte;
          cnt_nxt          = cnt_r + 2'd1;
        end else begin
          hex_nxt = 1'b0;
          cnt_nxt = 2'd0;
          if (cp16[15:10] == HIGH_SURR_TOP) begin
            e.h0_v     = held_v_r;
            e.h0       = held_r;
            held_nxt   = cp16[9:0];
            held_v_nxt = 1'b1;
          end else if (cp16[15:10] == LOW_SURR_TOP && held_v_r) begin
            u          = utf8_enc(21'h10000 + {1'b0, held_r, cp16[9:0]});
            held_v_nxt = 1'b0;
            held_nxt   = '0;
          end else begin
            e.h0_v     = held_v_r;
            e.h0       = held_r;
            held_v_nxt = 1'b0;
            held_nxt   = '0;
            u          = utf8_enc({5'd0, cp16});
          end
          for (int i = 0; i < 4; i++) e.body[i] = u.b[i];
          e.body_n = u.n;
        end
      end else begin
        // short sequence goes out literally
        e.h0_v     = held_v_r;
        e.h0       = held_r;
        held_v_nxt = 1'b0;
        held_nxt   = '0;
        e.body[0]  = CH_BACKSLASH;
        e.body[1]  = CH_U;
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < cnt_r) e.body[i+2] = chars_r[i];
        end
        e.body[{1'b0, cnt_r} + 3'd2] = in_byte;
        e.body_n = {1'b0, cnt_r} + 3'd3;
        hex_nxt  = 1'b0;
        cnt_nxt  = 2'd0;
      end
    end else if (esc_r) begin
      esc_nxt = 1'b0;
      if (in_byte == CH_U) begin
        hex_nxt = 1'b1;
        cnt_nxt = 2'd0;
      end else begin
        e.h0_v     = held_v_r;
        e.h0       = held_r;
        held_v_nxt = 1'b0;
        held_nxt   = '0;
        e.body[0]  = map_esc(in_byte);
        e.body_n   = 3'd1;
      end
    end else if (in_byte == CH_BACKSLASH) begin
      esc_nxt = 1'b1;
    end else begin
      e.h0_v     = held_v_r;
      e.h0       = held_r;
      held_v_nxt = 1'b0;
      held_nxt   = '0;
      e.body[0]  = in_byte;
      e.body_n   = 3'd1;
    end

    if (in_last_byte) begin
      e.last = 1'b1;
      if (held_v_nxt) begin
        if (e.h0_v) begin
          e.h1_v = 1'b1;
          e.h1   = held_nxt;
        end else begin
          e.h0_v = 1'b1;
          e.h0   = held_nxt;
        end
      end
      // a pending partial escape only survives when nothing else was emitted
      if (hex_nxt && cnt_nxt != 2'd0) begin
        e.body[0] = CH_BACKSLASH;
        e.body[1] = CH_U;
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < cnt_nxt) e.body[i+2] = chars_nxt[i];
        end
        e.body_n = {1'b0, cnt_nxt} + 3'd2;
      end
      esc_nxt    = 1'b0;
      hex_nxt    = 1'b0;
      cnt_nxt    = 2'd0;
      held_v_nxt = 1'b0;
      held_nxt   = '0;
    end
  end

  assign q_wdata = e;
  assign q_push  = acc && (e.last || e.h0_v || e.h1_v || e.body_n != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r    <= 1'b0;
      hex_r    <= 1'b0;
      cnt_r    <= 2'd0;
      held_r   <= '0;
      held_v_r <= 1'b0;
    end else if (acc) begin
      esc_r    <= esc_nxt;
      hex_r    <= hex_nxt;
      cnt_r    <= cnt_nxt;
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) chars_r <= chars_nxt;
  end

endmodule

FILE: src/jsu_fifo.sv
module jsu_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  jsu_pkg::entry_t wdata,
  output logic            full,
  input  logic            pop,
  output jsu_pkg::entry_t rdata,
  output logic            empty
);
  import jsu_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  entry_t          mem_r [QDEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  assign full  = (cnt_r == CW'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (pop)  rp_r <= (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + PW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue read while empty");

endmodule

FILE: src/jsu_back.sv
module jsu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  jsu_pkg::entry_t q_rdata,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_last_of_run,
  output logic            out_end_of_string
);
  import jsu_pkg::*;

  logic [3:0] k_r;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       bvalid_r, lrun_r, eos_r;

  logic       load, emit;
  logic [3:0] pre3, n_tot, j, jj;
  logic [7:0] cur_byte;
  logic       marker, final_b;

  assign load = !out_valid_r || !out_stall;
  assign emit = load && !q_empty;

  always_comb begin
    pre3     = q_rdata.h0_v ? 4'd3 : 4'd0;
    n_tot    = pre3 + {1'b0, q_rdata.body_n} + (q_rdata.h1_v ? 4'd3 : 4'd0);
    j        = k_r - pre3;
    jj       = j - {1'b0, q_rdata.body_n};
    marker   = (n_tot == 4'd0);
    final_b  = marker || (k_r == n_tot - 4'd1);
    if (q_rdata.h0_v && k_r < 4'd3) begin
      cur_byte = surr_byte(q_rdata.h0, k_r[1:0]);
    end else if (j < {1'b0, q_rdata.body_n}) begin
      cur_byte = q_rdata.body[j[2:0]];
    end else begin
      cur_byte = surr_byte(q_rdata.h1, jj[1:0]);
    end
    if (marker) cur_byte = 8'h00;
  end

  assign q_pop = emit && final_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= emit;
      if (emit) k_r <= final_b ? 4'd0 : k_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r   <= cur_byte;
      bvalid_r <= !marker;
      lrun_r   <= final_b;
      eos_r    <= final_b && q_rdata.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = byte_r;
  assign out_byte_valid    = bvalid_r;
  assign out_last_of_run   = lrun_r;
  assign out_end_of_string = eos_r;

  a_eos_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && eos_r |-> lrun_r)
    else $error("end of string without end of run");
  a_marker_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !bvalid_r |-> eos_r && byte_r == 8'h00)
    else $error("empty word that does not end the string");
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r < 4'd12)
    else $error("byte index past any word");
  a_index_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> k_r == 4'd0)
    else $error("byte index not cleared after a word");

endmodule
